// ----- design/bmhpq_pkg.sv -----
// Shared types, sizes and codes for the binary max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

	// Heap size and field widths
	localparam int DEPTH     = 128;
	localparam int PRIO_BITS = 8;
	localparam int TAG_BITS  = 16;

	// Derived widths: an index into the store, and a count that can hold DEPTH itself
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KID_W      = IDX_W + 2;
	localparam int IN_DATA_W  = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((PRIO_BITS + TAG_BITS + CNT_W + 7) / 8) * 8;

	// Operation codes carried on the input item
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_EXTRACTED = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// One heap entry
	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load_in;
		logic       set_res;
		logic [1:0] res_code;
		logic       rd_par;
		logic       rd_ext;
		logic       rd_kids;
		logic       wr_item;
		logic       up_step;
		logic       take_root;
		logic       dn_step;
		logic       cnt_inc;
		logic       out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
		logic pos_root;
		logic up_win;
		logic dn_stop;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/bmhpq_ctrl.sv -----
// Controller state machine that sequences inserts, extracts and the sift passes.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_ctrl
	import bmhpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_op,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP_RD   = 3'd1;
	localparam logic [2:0] S_UP_CMP  = 3'd2;
	localparam logic [2:0] S_EX_TAKE = 3'd3;
	localparam logic [2:0] S_DN_RD   = 3'd4;
	localparam logic [2:0] S_DN_CMP  = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	// Items are taken only between operations
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and command decode
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_INSERT) begin
						if (sts.full) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_OVERFLOW;
							state_nxt    = S_FIN;
						end else begin
							cmd.load_in = 1'b1;
							state_nxt   = S_UP_RD;
						end
					end else begin
						if (sts.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_EMPTY;
							state_nxt    = S_FIN;
						end else begin
							cmd.rd_ext = 1'b1;
							state_nxt  = S_EX_TAKE;
						end
					end
				end
			end
			S_UP_RD: begin
				if (sts.pos_root) begin
					cmd.wr_item  = 1'b1;
					cmd.cnt_inc  = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_nxt    = S_FIN;
				end else begin
					cmd.rd_par = 1'b1;
					state_nxt  = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_win) begin
					cmd.up_step = 1'b1;
					state_nxt   = S_UP_RD;
				end else begin
					cmd.wr_item  = 1'b1;
					cmd.cnt_inc  = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_nxt    = S_FIN;
				end
			end
			S_EX_TAKE: begin
				cmd.take_root = 1'b1;
				state_nxt     = sts.last_one ? S_FIN : S_DN_RD;
			end
			S_DN_RD: begin
				cmd.rd_kids = 1'b1;
				state_nxt   = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_stop) begin
					cmd.wr_item = 1'b1;
					state_nxt   = S_FIN;
				end else begin
					cmd.dn_step = 1'b1;
					state_nxt   = S_DN_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- design/bmhpq_dp.sv -----
// Datapath: heap store, entry count, moving entry, result and output registers.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_dp
	import bmhpq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic [PRIO_BITS-1:0] in_prio,
	input  wire logic [TAG_BITS-1:0]  in_tag,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                out_status,
	output logic [PRIO_BITS-1:0]      out_prio,
	output logic [TAG_BITS-1:0]       out_tag,
	output logic [CNT_W-1:0]          out_occ
);

	entry_t mem [DEPTH];

	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     pos_q;
	entry_t               item_q;
	entry_t               rda_q;
	entry_t               rdb_q;
	logic [1:0]           res_status_q;
	logic [PRIO_BITS-1:0] res_prio_q;
	logic [TAG_BITS-1:0]  res_tag_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [PRIO_BITS-1:0] out_prio_q;
	logic [TAG_BITS-1:0]  out_tag_q;
	logic [CNT_W-1:0]     out_occ_q;

	logic [IDX_W-1:0] par_idx;
	logic [KID_W-1:0] lc_idx;
	logic [KID_W-1:0] rc_idx;
	logic [KID_W-1:0] count_ext;
	logic             lc_ok;
	logic             rc_ok;
	logic             sel_l;
	logic             sel_r;
	logic [PRIO_BITS-1:0] best_prio;
	logic [IDX_W-1:0] best_idx;
	entry_t           best_data;
	logic             rd_en;
	logic [IDX_W-1:0] addr_a;
	logic [IDX_W-1:0] addr_b;
	logic             wr_en;
	entry_t           wr_data;

	// Parent and child positions of the hole
	assign par_idx   = (pos_q - IDX_W'(1)) >> 1;
	assign lc_idx    = {1'b0, pos_q, 1'b1};
	assign rc_idx    = KID_W'(lc_idx + 1'b1);
	assign count_ext = KID_W'(count_q);
	assign lc_ok     = lc_idx < count_ext;
	assign rc_ok     = rc_idx < count_ext;

	// Larger child, left preferred on ties, against the moving entry
	assign sel_l     = lc_ok && (rda_q.prio > item_q.prio);
	assign best_prio = sel_l ? rda_q.prio : item_q.prio;
	assign sel_r     = rc_ok && (rdb_q.prio > best_prio);
	assign best_idx  = sel_r ? rc_idx[IDX_W-1:0] : lc_idx[IDX_W-1:0];
	assign best_data = sel_r ? rdb_q : rda_q;

	// Read address selection for the two read ports
	always_comb begin
		rd_en  = cmd.rd_par || cmd.rd_ext || cmd.rd_kids;
		addr_a = '0;
		addr_b = '0;
		if (cmd.rd_par) begin
			addr_a = par_idx;
		end else if (cmd.rd_ext) begin
			addr_b = IDX_W'(count_q - 1'b1);
		end else if (cmd.rd_kids) begin
			addr_a = lc_idx[IDX_W-1:0];
			addr_b = rc_idx[IDX_W-1:0];
		end
	end

	// Write port: the moving entry, or the entry that moves into the hole
	assign wr_en   = cmd.wr_item || cmd.up_step || cmd.dn_step;
	assign wr_data = cmd.up_step ? rda_q : (cmd.dn_step ? best_data : item_q);

	// Heap store with registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rda_q <= mem[addr_a];
			rdb_q <= mem[addr_b];
		end
	end

	// Moving entry, hole position and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= '{tag: in_tag, prio: in_prio};
			pos_q  <= count_q[IDX_W-1:0];
		end else if (cmd.take_root) begin
			item_q <= rdb_q;
			pos_q  <= '0;
		end else if (cmd.up_step) begin
			pos_q <= par_idx;
		end else if (cmd.dn_step) begin
			pos_q <= best_idx;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_prio_q   <= '0;
			res_tag_q    <= '0;
		end else if (cmd.take_root) begin
			res_status_q <= ST_EXTRACTED;
			res_prio_q   <= rda_q.prio;
			res_tag_q    <= rda_q.tag;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_prio_q   <= res_prio_q;
			out_tag_q    <= res_tag_q;
			out_occ_q    <= count_q;
		end
	end

	// Entry count and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.take_root) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status back to the controller
	always_comb begin
		sts.full     = (count_q == CNT_W'(DEPTH));
		sts.empty    = (count_q == '0);
		sts.last_one = (count_q == CNT_W'(1));
		sts.pos_root = (pos_q == '0);
		sts.up_win   = (item_q.prio > rda_q.prio);
		sts.dn_stop  = !sel_l && !sel_r;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_prio   = out_prio_q;
	assign out_tag    = out_tag_q;
	assign out_occ    = out_occ_q;

	// The count never passes the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// An insert completes only with room left
	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (count_q < CNT_W'(DEPTH)))
		else $error("count incremented on a full heap");

	// An extract never takes from an empty heap
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_root |-> (count_q != '0))
		else $error("root taken from an empty heap");

	// Sifting down moves the hole deeper
	a_dn_deeper: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_step |=> (pos_q > $past(pos_q)))
		else $error("sift-down did not descend");

	// Sifting up moves the hole towards the root
	a_up_higher: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_step |=> (pos_q < $past(pos_q)))
		else $error("sift-up did not ascend");

endmodule

`default_nettype wire

// ----- design/binary_max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue: stream ports, controller and datapath.
//
// Usage: each input item on the s_axis channel is one operation, selected by
// s_axis_tuser (insert or extract). An insert carries a priority and a tag;
// an extract ignores them. Every item gives exactly one result item on the
// m_axis channel with a status, the extracted priority and tag (zero unless
// an entry was extracted) and the occupancy after the operation.
// Items are processed one at a time. A rejected insert or an empty extract
// goes straight to the result; an insert climbs the levels from the first
// free position, and an extract that does not take the only entry moves the
// last entry to the root and sifts it down the levels. Each level of the sift
// loop is a store read with registered data followed by a compare-and-write.
// A result waits in an output register; the next item is accepted while it
// waits, but that item cannot deliver its own result until the receiver has
// taken the previous one, so a stalled receiver halts the queue after one item.
// Reset empties the queue at once; the store contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_priority_queue
	import bmhpq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// Fields from bit 0: priority_req, tag
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: op
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// Fields from bit 0: out_priority, out_tag, occupancy
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// Fields from bit 0: status
	output logic [1:0]                 m_axis_tuser
);

	cmd_t                 cmd;
	sts_t                 sts;
	logic [PRIO_BITS-1:0] out_prio;
	logic [TAG_BITS-1:0]  out_tag;
	logic [CNT_W-1:0]     out_occ;

	// Operation sequencing
	bmhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Heap store and registers
	bmhpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_prio    (s_axis_tdata[PRIO_BITS-1:0]),
		.in_tag     (s_axis_tdata[PRIO_BITS+TAG_BITS-1:PRIO_BITS]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_prio   (out_prio),
		.out_tag    (out_tag),
		.out_occ    (out_occ)
	);

	// Pack the result fields, zero-filled to whole bytes
	assign m_axis_tdata = OUT_DATA_W'({out_occ, out_tag, out_prio});

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the binary max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import bmhpq_pkg::*;

	// Expected content of one result item
	typedef struct packed {
		logic [1:0]           status;
		logic [PRIO_BITS-1:0] prio;
		logic [TAG_BITS-1:0]  tag;
		logic [CNT_W-1:0]     occ;
	} heap_result_t;

	// One row of the directed sequence; the result is typed in only where it is obvious
	typedef struct packed {
		logic                 op;
		logic [PRIO_BITS-1:0] prio;
		logic [TAG_BITS-1:0]  tag;
		logic                 typed;
		heap_result_t         want;
	} directed_row_t;

	typedef enum int {EP_MIXED, EP_FILL, EP_DRAIN} episode_t;

	localparam int DIRECTED_ROWS = 21;
	localparam int RANDOM_ITEMS  = 1880;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int SETTLE_CYCLES = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;

	// Predictor state: its own copy of the heap
	entry_t       heap_model[DEPTH];
	int unsigned  heap_fill = 0;
	heap_result_t pending_results[$];
	int unsigned  bad_results = 0;

	// Idling controls for the sender and the receiver
	int unsigned  sender_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  sender_burst_left = 0;
	bit           hold_off_req = 1'b0;

	directed_row_t directed_rows[DIRECTED_ROWS] = '{
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY,     8'h00, 16'h0000, 8'd0}},
		'{OP_INSERT,  8'h00, 16'h0000, 1'b1, '{ST_INSERTED,  8'h00, 16'h0000, 8'd1}},
		'{OP_EXTRACT, 8'hff, 16'hffff, 1'b1, '{ST_EXTRACTED, 8'h00, 16'h0000, 8'd0}},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY,     8'h00, 16'h0000, 8'd0}},
		'{OP_INSERT,  8'hff, 16'hffff, 1'b1, '{ST_INSERTED,  8'h00, 16'h0000, 8'd1}},
		'{OP_INSERT,  8'hff, 16'h0001, 1'b1, '{ST_INSERTED,  8'h00, 16'h0000, 8'd2}},
		'{OP_INSERT,  8'h00, 16'h8000, 1'b1, '{ST_INSERTED,  8'h00, 16'h0000, 8'd3}},
		'{OP_INSERT,  8'hc8, 16'h1234, 1'b0, '0},
		'{OP_INSERT,  8'hc8, 16'h4321, 1'b0, '0},
		'{OP_INSERT,  8'hff, 16'haaaa, 1'b0, '0},
		'{OP_INSERT,  8'h01, 16'h5555, 1'b0, '0},
		'{OP_INSERT,  8'h80, 16'h00ff, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b1, '{ST_EXTRACTED, 8'hff, 16'hffff, 8'd7}},
		'{OP_EXTRACT, 8'h5a, 16'ha5a5, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_EXTRACT, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY,     8'h00, 16'h0000, 8'd0}}
	};

	binary_max_heap_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Apply one operation to the heap copy and return the result it gives.
	function automatic heap_result_t heap_apply(logic op, logic [PRIO_BITS-1:0] prio,
			logic [TAG_BITS-1:0] tag);
		heap_result_t res;
		entry_t       tmp;
		int unsigned  pos;
		int unsigned  up;
		int unsigned  lc;
		int unsigned  rc;
		int unsigned  best;
		res = '0;
		if (op == OP_INSERT) begin
			if (heap_fill >= DEPTH) begin
				res.status = ST_OVERFLOW;
			end else begin
				heap_model[heap_fill].prio = prio;
				heap_model[heap_fill].tag = tag;
				// Climb while strictly greater than the parent.
				pos = heap_fill;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_model[pos].prio <= heap_model[up].prio)
						break;
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[up];
					heap_model[up] = tmp;
					pos = up;
				end
				heap_fill++;
				res.status = ST_INSERTED;
			end
		end else begin
			if (heap_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.status = ST_EXTRACTED;
				res.prio = heap_model[0].prio;
				res.tag = heap_model[0].tag;
				heap_model[0] = heap_model[heap_fill - 1];
				heap_fill--;
				// Descend towards the strictly larger child; the left one wins a tie.
				pos = 0;
				while (pos < heap_fill) begin
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					best = pos;
					if (lc < heap_fill && heap_model[lc].prio > heap_model[best].prio)
						best = lc;
					if (rc < heap_fill && heap_model[rc].prio > heap_model[best].prio)
						best = rc;
					if (best == pos)
						break;
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[best];
					heap_model[best] = tmp;
					pos = best;
				end
			end
		end
		res.occ = heap_fill[CNT_W-1:0];
		return res;
	endfunction

	// Offer one item, wait until it is taken, then record the result it should give.
	task automatic offer_item(logic op, logic [PRIO_BITS-1:0] prio, logic [TAG_BITS-1:0] tag,
			bit typed, heap_result_t want);
		int unsigned  gap;
		heap_result_t predicted;
		gap = 0;
		if (sender_burst_left > 0) begin
			sender_burst_left--;
		end else begin
			if ($urandom_range(99) < 4)
				sender_burst_left = $urandom_range(30, 10);
			while (gap < 40 && $urandom_range(99) < sender_idle_pct)
				gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({tag, prio});
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		predicted = heap_apply(op, prio, tag);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Random priority, often from a tiny range so that equal priorities meet.
	function automatic logic [PRIO_BITS-1:0] pick_prio();
		if ($urandom_range(1) == 0)
			return PRIO_BITS'($urandom_range(3));
		return PRIO_BITS'($urandom_range(255));
	endfunction

	// Receiver: random stalls, stretches without stalls, and the long hold-off on request.
	initial begin
		int unsigned hold_left;
		int unsigned clear_left;
		hold_left = 0;
		clear_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (clear_left > 0) begin
				clear_left--;
				m_axis_tready <= 1'b1;
			end else begin
				if ($urandom_range(99) < 3)
					clear_left = $urandom_range(60, 20);
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Result checker: compare each result item with the oldest expectation.
	always @(posedge clk) begin
		heap_result_t want;
		heap_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.prio = m_axis_tdata[0 +: PRIO_BITS];
			got.tag = m_axis_tdata[PRIO_BITS +: TAG_BITS];
			got.occ = m_axis_tdata[PRIO_BITS + TAG_BITS +: CNT_W];
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("Unexpected result: status %0d prio %0d tag %h occ %0d",
						got.status, got.prio, got.tag, got.occ);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.prio !== want.prio ||
						got.tag !== want.tag || got.occ !== want.occ) begin
					bad_results++;
					if (bad_results <= 10)
						$display("Mismatch: expected status %0d prio %0d tag %h occ %0d, got status %0d prio %0d tag %h occ %0d",
							want.status, want.prio, want.tag, want.occ,
							got.status, got.prio, got.tag, got.occ);
				end
			end
		end
	end

	// Stimulus: directed rows, then four idling phases of random episodes.
	initial begin
		int unsigned sent;
		int unsigned quota;
		int unsigned extra_left;
		int unsigned run_len;
		episode_t    episode;
		logic        op;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_item(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].tag,
				directed_rows[i].typed, directed_rows[i].want);
		// Withdraw the last item so that it is not taken a second time.
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);

		quota = RANDOM_ITEMS / 4;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			sent = 0;
			while (sent < quota) begin
				// The opening episode of each phase fills the heap past full.
				episode = (sent == 0) ? EP_FILL : episode_t'($urandom_range(2));
				case (episode)
					EP_FILL: begin
						extra_left = $urandom_range(3, 1);
						while (extra_left > 0) begin
							op = ($urandom_range(9) == 0) ? OP_EXTRACT : OP_INSERT;
							if (op == OP_INSERT && heap_fill == DEPTH)
								extra_left--;
							offer_item(op, pick_prio(), TAG_BITS'($urandom_range(65535)), 1'b0, '0);
							sent++;
							if (phase == 0 && sent == 60)
								hold_off_req = 1'b1;
						end
					end
					EP_DRAIN: begin
						extra_left = $urandom_range(2, 1);
						while (extra_left > 0) begin
							op = ($urandom_range(9) == 0) ? OP_INSERT : OP_EXTRACT;
							if (op == OP_EXTRACT && heap_fill == 0)
								extra_left--;
							offer_item(op, pick_prio(), TAG_BITS'($urandom_range(65535)), 1'b0, '0);
							sent++;
						end
					end
					default: begin
						run_len = $urandom_range(80, 20);
						for (int n = 0; n < run_len; n++) begin
							op = $urandom_range(1) ? OP_EXTRACT : OP_INSERT;
							offer_item(op, pick_prio(), TAG_BITS'($urandom_range(65535)), 1'b0, '0);
							sent++;
						end
					end
				endcase
			end
			// Hold the sender back until every outstanding result has come.
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			wait (pending_results.size() == 0);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_results == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog for a run that hangs.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
